// File: sv/huffman_tree_decoder_assert.svh
// Assertion macros for the Huffman tree decoder checker.
// Self-contained; used by htd_checker.sv.
`ifndef HUFFMAN_TREE_DECODER_ASSERT_SVH
`define HUFFMAN_TREE_DECODER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define HTD_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define HTD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/htd_pkg.sv
// Shared types and constants of the Huffman tree decoder.
// No dependencies.
package htd_pkg;

    localparam int NODE_W     = 8;
    localparam int CHILD_W    = 9;
    localparam int BYTE_W     = 8;
    localparam int CHUNK_W    = 32;
    localparam int BIT_IDX_W  = 3;
    localparam int S_TDATA_W  = 64;

    localparam int NODE_LSB   = 0;
    localparam int SIDE_BIT   = 8;
    localparam int VALUE_LSB  = 9;
    localparam int LEN_LSB    = 18;
    localparam int DATA_LSB   = 50;

    localparam logic [BIT_IDX_W-1:0] LAST_BIT_IDX = 3'd7;
    localparam int LEAF_FLAG = CHILD_W - 1;

    typedef enum logic [1:0] {
        REQ_DICT  = 2'd0,
        REQ_START = 2'd1,
        REQ_DATA  = 2'd2
    } t_req;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_FLUSH
    } t_state;

endpackage

// File: sv/huffman_tree_decoder.sv
// Huffman tree-walk decoder: child table in htd_ram, one tree step per cycle while m_axis is not stalled.
// Depends on htd_pkg and htd_ram.
//
//  channel  | dir | tdata                     | tuser          | tlast
//  s_axis   | in  | node, side, value, length, | request type   | -
//           |     | data byte                 |                |
//  m_axis   | out | decoded byte              | chunk end      | last of item
//
// A data byte is accepted in S_IDLE, then S_WALK steps once per used bit
// (up to 8), paced by the child-table read loop; S_FLUSH follows if it yields
// two or more bytes and ends on a leaf. Dict writes and starts finish in S_IDLE.
// Reset: synchronous, active low; walk at root, no active chunk, table kept.
// The walk holds while a decoded byte waits on m_axis.
module huffman_tree_decoder
    import htd_pkg::*;
#(
    parameter int TREE_NODES   = 255,
    parameter int LENGTH_WIDTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // node_index, child_side, child_value, chunk_length, data_byte, zero pad
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // req_type
    input  logic [1:0]           s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // out_byte
    output logic [BYTE_W-1:0]    m_axis_tdata,
    output logic                 m_axis_tlast,
    // chunk_end
    output logic [0:0]           m_axis_tuser
);

    localparam int ADDR_W = $clog2(2 * TREE_NODES);
    localparam logic [NODE_W-1:0] ROOT = NODE_W'(TREE_NODES - 1);

    t_state r_state, n_state;

    logic [NODE_W-1:0]       r_node, n_node;
    logic [LENGTH_WIDTH-1:0] r_remaining, n_remaining;
    logic                    r_active, n_active;
    logic [BYTE_W-1:0]       r_bits, n_bits;
    logic [BIT_IDX_W-1:0]    r_bit_idx, n_bit_idx;
    logic                    r_rd_zero, n_rd_zero;
    logic                    r_pend_valid, n_pend_valid;
    logic [BYTE_W-1:0]       r_pend_byte, n_pend_byte;
    logic                    r_pend_end, n_pend_end;
    logic                    r_m_valid, n_m_valid;
    logic [BYTE_W-1:0]       r_m_byte, n_m_byte;
    logic                    r_m_last, n_m_last;
    logic                    r_m_end, n_m_end;

    logic                    in_accept;
    logic                    go;
    logic [NODE_W-1:0]       in_node;
    logic                    in_side;
    logic [CHILD_W-1:0]      in_value;
    logic [CHUNK_W-1:0]      in_length;
    logic [BYTE_W-1:0]       in_data;

    logic                    ram_we;
    logic [ADDR_W-1:0]       ram_waddr;
    logic                    ram_re;
    logic [ADDR_W-1:0]       ram_raddr;
    logic [CHILD_W-1:0]      ram_rdata;

    logic [CHILD_W-1:0]      rd_value;
    logic                    is_leaf;
    logic                    last_bit;
    logic [LENGTH_WIDTH-1:0] rem_dec;
    logic                    chunk_done;
    logic                    walk_final;
    logic [NODE_W-1:0]       next_node;
    logic                    next_bit;
    logic [BIT_IDX_W-1:0]    idx_inc;
    logic [NODE_W-1:0]       rd_node;
    logic                    rd_side;
    logic                    rd_oob;

    assign in_node   = s_axis_tdata[NODE_LSB +: NODE_W];
    assign in_side   = s_axis_tdata[SIDE_BIT];
    assign in_value  = s_axis_tdata[VALUE_LSB +: CHILD_W];
    assign in_length = s_axis_tdata[LEN_LSB +: CHUNK_W];
    assign in_data   = s_axis_tdata[DATA_LSB +: BYTE_W];

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign go            = !r_m_valid || m_axis_tready;

    assign rd_value   = r_rd_zero ? '0 : ram_rdata;
    assign is_leaf    = !rd_value[LEAF_FLAG];
    assign last_bit   = (r_bit_idx == LAST_BIT_IDX);
    assign rem_dec    = r_remaining - LENGTH_WIDTH'(1);
    assign chunk_done = is_leaf && (rem_dec == '0);
    assign walk_final = last_bit || chunk_done;
    assign next_node  = is_leaf ? ROOT : rd_value[NODE_W-1:0];
    assign idx_inc    = r_bit_idx + BIT_IDX_W'(1);
    assign next_bit   = r_bits[idx_inc];

    assign ram_we    = in_accept && (s_axis_tuser == REQ_DICT)
                       && ({1'b0, in_node} < (NODE_W + 1)'(TREE_NODES));
    assign ram_waddr = ADDR_W'({in_node, in_side});

    // read address: first bit of a new byte, else the step after this one
    always_comb begin
        if (r_state == S_IDLE) begin
            rd_node = r_node;
            rd_side = in_data[0];
            ram_re  = in_accept && (s_axis_tuser == REQ_DATA) && r_active;
        end else begin
            rd_node = next_node;
            rd_side = next_bit;
            ram_re  = (r_state == S_WALK) && go && !walk_final;
        end
        rd_oob    = ({1'b0, rd_node} >= (NODE_W + 1)'(TREE_NODES));
        ram_raddr = rd_oob ? '0 : ADDR_W'({rd_node, rd_side});
    end

    htd_ram #(
        .WIDTH (CHILD_W),
        .DEPTH (2 * TREE_NODES)
    ) u_child_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (in_value),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_accept && (s_axis_tuser == REQ_DATA) && r_active) begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (go && walk_final) begin
                    n_state = (is_leaf && r_pend_valid) ? S_FLUSH : S_IDLE;
                end
            end
            S_FLUSH: begin
                if (go) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_node       = r_node;
        n_remaining  = r_remaining;
        n_active     = r_active;
        n_bits       = r_bits;
        n_bit_idx    = r_bit_idx;
        n_rd_zero    = ram_re ? rd_oob : r_rd_zero;
        n_pend_valid = r_pend_valid;
        n_pend_byte  = r_pend_byte;
        n_pend_end   = r_pend_end;
        n_m_valid    = r_m_valid && !m_axis_tready;
        n_m_byte     = r_m_byte;
        n_m_last     = r_m_last;
        n_m_end      = r_m_end;

        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    case (s_axis_tuser)
                        REQ_START: begin
                            n_remaining = in_length[LENGTH_WIDTH-1:0];
                            n_node      = ROOT;
                            n_active    = (in_length[LENGTH_WIDTH-1:0] != '0);
                        end
                        REQ_DATA: begin
                            n_bits    = in_data;
                            n_bit_idx = '0;
                        end
                        default: ;
                    endcase
                end
            end
            S_WALK: begin
                if (go) begin
                    n_bit_idx = idx_inc;
                    n_node    = next_node;
                    if (is_leaf) begin
                        n_remaining = rem_dec;
                        if (chunk_done) begin
                            n_active = 1'b0;
                        end
                    end
                    // hold one decoded byte back until its last flag is known
                    if (r_pend_valid && (is_leaf || walk_final)) begin
                        n_m_valid    = 1'b1;
                        n_m_byte     = r_pend_byte;
                        n_m_end      = r_pend_end;
                        n_m_last     = !is_leaf && walk_final;
                        n_pend_valid = 1'b0;
                    end
                    if (is_leaf) begin
                        if (walk_final && !r_pend_valid) begin
                            n_m_valid = 1'b1;
                            n_m_byte  = rd_value[BYTE_W-1:0];
                            n_m_end   = chunk_done;
                            n_m_last  = 1'b1;
                        end else begin
                            n_pend_valid = 1'b1;
                            n_pend_byte  = rd_value[BYTE_W-1:0];
                            n_pend_end   = chunk_done;
                        end
                    end
                end
            end
            S_FLUSH: begin
                if (go) begin
                    n_m_valid    = 1'b1;
                    n_m_byte     = r_pend_byte;
                    n_m_end      = r_pend_end;
                    n_m_last     = 1'b1;
                    n_pend_valid = 1'b0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_node       <= ROOT;
            r_remaining  <= '0;
            r_active     <= 1'b0;
            r_pend_valid <= 1'b0;
            r_m_valid    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_node       <= n_node;
            r_remaining  <= n_remaining;
            r_active     <= n_active;
            r_pend_valid <= n_pend_valid;
            r_m_valid    <= n_m_valid;
        end
        r_bits      <= n_bits;
        r_bit_idx   <= n_bit_idx;
        r_rd_zero   <= n_rd_zero;
        r_pend_byte <= n_pend_byte;
        r_pend_end  <= n_pend_end;
        r_m_byte    <= n_m_byte;
        r_m_last    <= n_m_last;
        r_m_end     <= n_m_end;
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_byte;
    assign m_axis_tlast  = r_m_last;
    assign m_axis_tuser  = r_m_end;

endmodule

// File: sv/htd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module htd_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 510,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/htd_checker.sv
// Port-level checker for huffman_tree_decoder, bound to the top level.
// Depends on htd_pkg and huffman_tree_decoder_assert.svh.
`include "huffman_tree_decoder_assert.svh"

module htd_checker
    import htd_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic [1:0]           s_axis_tuser,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [BYTE_W-1:0]    m_axis_tdata,
    input logic                 m_axis_tlast,
    input logic [0:0]           m_axis_tuser
);

    `HTD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "output transfer dropped")

    `HTD_ASSERT_IMPLY(a_end_is_last, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser[0],
        m_axis_tlast, "chunk end without last")

    `HTD_ASSERT_NEXT(a_ctrl_one_cycle, i_clk, i_rst_n,
        s_axis_tvalid && s_axis_tready && s_axis_tuser != REQ_DATA,
        s_axis_tready, "control transfer not done in one cycle")

endmodule

bind huffman_tree_decoder htd_checker u_htd_checker (.*);

// File: verif/tb.sv
// Self-checking testbench for huffman_tree_decoder: loads random trees, feeds
// chunk starts and compressed bytes, and compares every decoded byte against
// a behavioral tree walker. Depends on htd_pkg and the decoder RTL.
module tb
    import htd_pkg::*;
();

    localparam int                TREE_NODES = 255;
    localparam logic [NODE_W-1:0] ROOT       = NODE_W'(TREE_NODES - 1);
    localparam int                LEAF_LIMIT = 256;
    localparam logic [1:0]        REQ_SPARE  = 2'd3;
    localparam int                PLAN       = 0;
    localparam int                LIVE       = 1;
    localparam int                PAD_W      = S_TDATA_W - DATA_LSB - BYTE_W;

    typedef struct packed {
        logic [1:0]         req;
        logic [NODE_W-1:0]  node;
        logic               side;
        logic [CHILD_W-1:0] value;
        logic [CHUNK_W-1:0] len;
        logic [BYTE_W-1:0]  data;
    } stream_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] sym;
        logic              last;
        logic              chunk_end;
    } decoded_t;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    logic [1:0]           s_axis_tuser = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [BYTE_W-1:0]    m_axis_tdata;
    logic                 m_axis_tlast;
    logic [0:0]           m_axis_tuser;

    // two walker copies: one steers stimulus generation, one tracks the DUT
    logic [CHILD_W-1:0] tree_child [2][TREE_NODES][2];
    bit                 tree_known [2][TREE_NODES][2];
    logic [NODE_W-1:0]  walk_node [2];
    logic [CHUNK_W-1:0] bytes_left [2];
    bit                 chunk_on [2];

    stream_item_t      pending [$];
    decoded_t          expected_bytes [$];
    logic [NODE_W-1:0] tree_nodes [$];
    stream_item_t      cur_item;
    decoded_t          want;
    int                counted = 0;
    int                errors = 0;
    int                send_gap = 0;
    int                sink_gap = 0;
    int                send_calm = 0;
    int                sink_calm = 0;

    huffman_tree_decoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic bit walk_item(input int m, input stream_item_t it);
        bit                 blank;
        logic [CHILD_W-1:0] kid;
        decoded_t           res;
        int                 made;
        blank = 1'b0;
        made = 0;
        case (it.req)
            REQ_DICT: begin
                if (it.node < TREE_NODES) begin
                    tree_child[m][it.node][it.side] = it.value;
                    tree_known[m][it.node][it.side] = 1'b1;
                end
            end
            REQ_START: begin
                bytes_left[m] = it.len;
                walk_node[m] = ROOT;
                chunk_on[m] = (it.len != '0);
            end
            REQ_DATA: begin
                if (chunk_on[m]) begin
                    for (int b = 0; b < BYTE_W; b++) begin
                        if (walk_node[m] >= TREE_NODES) begin
                            kid = '0;
                        end else begin
                            kid = tree_child[m][walk_node[m]][it.data[b]];
                            if (!tree_known[m][walk_node[m]][it.data[b]]) blank = 1'b1;
                        end
                        if (kid < LEAF_LIMIT) begin
                            bytes_left[m] = bytes_left[m] - 1'b1;
                            walk_node[m] = ROOT;
                            res.sym = kid[BYTE_W-1:0];
                            res.last = 1'b0;
                            res.chunk_end = (bytes_left[m] == '0);
                            if (m == LIVE) expected_bytes.push_back(res);
                            made++;
                            if (bytes_left[m] == '0) begin
                                chunk_on[m] = 1'b0;
                                break;
                            end
                        end else begin
                            walk_node[m] = kid[NODE_W-1:0];
                        end
                    end
                    if (m == LIVE && made > 0)
                        expected_bytes[expected_bytes.size() - 1].last = 1'b1;
                end
            end
            default: ;
        endcase
        return blank;
    endfunction

    // queue an item unless it would walk into a never-written child
    function automatic bit plan(input stream_item_t it);
        logic [NODE_W-1:0]  n0;
        logic [CHUNK_W-1:0] r0;
        bit                 a0;
        n0 = walk_node[PLAN];
        r0 = bytes_left[PLAN];
        a0 = chunk_on[PLAN];
        if (walk_item(PLAN, it)) begin
            walk_node[PLAN] = n0;
            bytes_left[PLAN] = r0;
            chunk_on[PLAN] = a0;
            return 1'b0;
        end
        pending.push_back(it);
        counted++;
        return 1'b1;
    endfunction

    function automatic stream_item_t make_item(input logic [1:0] req);
        stream_item_t it;
        it.req = req;
        it.node = NODE_W'($urandom);
        it.side = 1'($urandom);
        it.value = CHILD_W'($urandom);
        it.len = $urandom;
        it.data = BYTE_W'($urandom);
        return it;
    endfunction

    function automatic void add_dict(input logic [NODE_W-1:0] node, input logic side,
                                     input logic [CHILD_W-1:0] value);
        stream_item_t it;
        it = make_item(REQ_DICT);
        it.node = node;
        it.side = side;
        it.value = value;
        void'(plan(it));
    endfunction

    function automatic void add_start(input logic [CHUNK_W-1:0] len);
        stream_item_t it;
        it = make_item(REQ_START);
        it.len = len;
        void'(plan(it));
    endfunction

    function automatic void add_data(input logic [BYTE_W-1:0] data);
        stream_item_t it;
        it = make_item(REQ_DATA);
        it.data = data;
        void'(plan(it));
    endfunction

    function automatic void add_random_data();
        for (int t = 0; t < 20; t++) begin
            if (plan(make_item(REQ_DATA))) break;
        end
    endfunction

    function automatic void build_tree(input int inner);
        logic [NODE_W-1:0] pool [$];
        logic [NODE_W-1:0] open_node [$];
        logic              open_side [$];
        logic [NODE_W-1:0] n;
        logic [NODE_W-1:0] pick;
        logic              s;
        int                k;
        logic [CHILD_W-1:0] value;
        tree_nodes.delete();
        tree_nodes.push_back(ROOT);
        for (int i = 0; i < TREE_NODES - 1; i++) pool.push_back(NODE_W'(i));
        open_node.push_back(ROOT);
        open_side.push_back(1'b0);
        open_node.push_back(ROOT);
        open_side.push_back(1'b1);
        while (open_node.size() > 0) begin
            n = open_node.pop_front();
            s = open_side.pop_front();
            if (inner > 0 && $urandom_range(0, 2) != 0) begin
                k = $urandom_range(0, pool.size() - 1);
                pick = pool[k];
                pool.delete(k);
                inner--;
                value = CHILD_W'(LEAF_LIMIT + int'(pick));
                open_node.push_back(pick);
                open_side.push_back(1'b0);
                open_node.push_back(pick);
                open_side.push_back(1'b1);
                tree_nodes.push_back(pick);
            end else begin
                value = CHILD_W'($urandom_range(0, LEAF_LIMIT - 1));
            end
            add_dict(n, s, value);
        end
    endfunction

    function automatic logic [CHUNK_W-1:0] pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85) return $urandom_range(1, 24);
        if (r < 95) return $urandom_range(25, 80);
        return $urandom;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic void fill_stimulus();
        int budget;
        int r;
        logic [CHILD_W-1:0] value;
        // root: 0 -> node 0, 1 -> 0xFF; node 0: 0 -> 0x00, 1 -> back to root
        add_dict(ROOT, 1'b0, CHILD_W'(LEAF_LIMIT));
        add_dict(ROOT, 1'b1, CHILD_W'(8'hFF));
        add_dict(8'd0, 1'b0, CHILD_W'(0));
        add_dict(8'd0, 1'b1, CHILD_W'(LEAF_LIMIT + int'(ROOT)));
        add_dict(8'hFF, 1'b0, 9'h1AB);
        add_data(8'hA5);
        void'(plan(make_item(REQ_SPARE)));
        add_start('0);
        add_data(8'h3C);
        add_start(32'd8);
        add_data(8'hFF);
        add_data(8'h00);
        add_start(32'hFFFF_FFFF);
        add_data(8'h00);
        add_data(8'h02);
        add_data(8'h01);
        add_start(32'd3);
        add_data(8'hC8);
        add_start(32'd5);
        add_data(8'h01);
        add_dict(8'd0, 1'b0, CHILD_W'(8'h5A));
        add_data(8'h00);
        add_dict(8'd0, 1'b1, 9'h1FF);
        add_start(32'd2);
        add_data(8'hFA);

        while (counted < 430) begin
            if (tree_nodes.size() == 0 || $urandom_range(0, 3) == 0)
                build_tree(($urandom_range(0, 9) == 0) ? $urandom_range(20, 120)
                                                       : $urandom_range(0, 12));
            add_start(pick_length());
            budget = $urandom_range(1, 20);
            while (budget > 0 && chunk_on[PLAN]) begin
                r = $urandom_range(0, 99);
                if (r < 4) begin
                    void'(plan(make_item(REQ_SPARE)));
                end else if (r < 8) begin
                    if ($urandom_range(0, 1) == 0)
                        value = CHILD_W'($urandom_range(0, LEAF_LIMIT - 1));
                    else
                        value = CHILD_W'(LEAF_LIMIT + int'(
                            tree_nodes[$urandom_range(0, tree_nodes.size() - 1)]));
                    add_dict(tree_nodes[$urandom_range(0, tree_nodes.size() - 1)],
                             1'($urandom), value);
                end else if (r < 10) begin
                    add_start(pick_length());
                end else begin
                    add_random_data();
                end
                budget--;
            end
            if ($urandom_range(0, 9) < 3) begin
                repeat ($urandom_range(1, 2)) add_random_data();
            end
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) void'(walk_item(LIVE, cur_item));
            if (send_calm > 0) send_calm--;
            else if ($urandom_range(0, 199) == 0) send_calm = 200;
            if (!s_axis_tvalid || s_axis_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending.size() > 0) begin
                    cur_item = pending.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser <= cur_item.req;
                    s_axis_tdata <= {{PAD_W{1'b0}}, cur_item.data, cur_item.len,
                                     cur_item.value, cur_item.side, cur_item.node};
                    send_gap = (send_calm > 0) ? 0 : pick_gap();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_bytes.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected transfer: byte %h last %b end %b",
                                 m_axis_tdata, m_axis_tlast, m_axis_tuser[0]);
                end else begin
                    want = expected_bytes.pop_front();
                    if (want.sym !== m_axis_tdata || want.last !== m_axis_tlast ||
                        want.chunk_end !== m_axis_tuser[0]) begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: expected byte %h last %b end %b, got %h %b %b",
                                     want.sym, want.last, want.chunk_end,
                                     m_axis_tdata, m_axis_tlast, m_axis_tuser[0]);
                    end
                end
            end
            if (sink_calm > 0) sink_calm--;
            else if ($urandom_range(0, 199) == 0) sink_calm = 200;
            if (sink_gap > 0) begin
                sink_gap--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                sink_gap = (sink_calm > 0) ? 0 : pick_gap();
            end
        end
    end

    initial begin
        for (int m = 0; m < 2; m++) begin
            walk_node[m] = ROOT;
            bytes_left[m] = '0;
            chunk_on[m] = 1'b0;
            for (int n = 0; n < TREE_NODES; n++) begin
                tree_known[m][n][0] = 1'b0;
                tree_known[m][n][1] = 1'b0;
            end
        end
        fill_stimulus();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (pending.size() != 0 || s_axis_tvalid) @(posedge i_clk);
        while (expected_bytes.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("FAILURE");
        $finish;
    end
endmodule
